// File: sv/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, codes and helper functions of the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned MaxTextBytes = 65536;
  localparam int unsigned OffsetCapInt = ((MaxTextBytes - 1) < 65535) ?
                                         (MaxTextBytes - 1) : 65535;
  localparam logic [15:0] OffsetCap    = 16'(OffsetCapInt);
  localparam logic [15:0] CountMax     = 16'hFFFF;

  // scan modes
  localparam logic [2:0] ModeEmpty      = 3'd0;
  localparam logic [2:0] ModeWord       = 3'd1;
  localparam logic [2:0] ModeSkip       = 3'd2;
  localparam logic [2:0] ModeSlashEmpty = 3'd3;
  localparam logic [2:0] ModeSlashWord  = 3'd4;
  localparam logic [2:0] ModeLine       = 3'd5;
  localparam logic [2:0] ModeBlock      = 3'd6;
  localparam logic [2:0] ModeStar       = 3'd7;

  // token kinds
  localparam logic [1:0] KindWord  = 2'd0;
  localparam logic [1:0] KindPunct = 2'd1;
  localparam logic [1:0] KindEnd   = 2'd2;

  // special bytes
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;

  localparam int unsigned ResPerByte = 3;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [15:0] off;
    logic [15:0] line;
    logic [15:0] col;
  } pos_t;

  localparam pos_t PosReset = '{off: 16'd0, line: 16'd1, col: 16'd1};

  typedef struct packed {
    logic [1:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic [7:0]  punct_char;
  } token_t;

  // all tokens caused by one byte, packed from index 0
  typedef struct packed {
    logic [1:0]                  count;
    token_t [ResPerByte-1:0]     recs;
  } bundle_t;

  function automatic logic is_punct(logic [7:0] c);
    logic r;
    unique case (c)
      8'h22, 8'h27, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h26, 8'h7C, 8'h5E,
      8'h7E, 8'h3C, 8'h3E, 8'h3D, 8'h21, 8'h3F, 8'h3A, 8'h3B, 8'h2C,
      8'h2E, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // position after consuming byte c, all counters saturating
  function automatic pos_t advance_pos(pos_t p, logic [7:0] c);
    pos_t r;
    r = p;
    if (p.off < OffsetCap) r.off = p.off + 16'd1;
    if (c == ChNl) begin
      if (p.line < CountMax) r.line = p.line + 16'd1;
      r.col = 16'd1;
    end else if (p.col < CountMax) begin
      r.col = p.col + 16'd1;
    end
    return r;
  endfunction

endpackage

// File: sv/stt_if.sv
// ----------------------------------------------------------------------------
// stt_if
// Handshake channels of the tokenizer: text bytes in, tokens out.
// ----------------------------------------------------------------------------
interface stt_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface stt_token_if;
  logic        valid;
  logic        ready;
  logic [1:0]  token_kind;
  logic [15:0] start_offset;
  logic [15:0] token_length;
  logic [15:0] line_number;
  logic [15:0] column_number;
  logic [7:0]  punct_char;
  logic        last_result;

  modport source (output valid, output token_kind, output start_offset,
                  output token_length, output line_number, output column_number,
                  output punct_char, output last_result, input ready);
  modport sink   (input valid, input token_kind, input start_offset,
                  input token_length, input line_number, input column_number,
                  input punct_char, input last_result, output ready);
endinterface

// File: sv/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front
// Scanner: takes one byte a cycle while the queue has room, tracks mode and
// position, and builds the bundle of tokens that the byte causes.
// ----------------------------------------------------------------------------
module stt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  stt_char_if.sink          char_i,
  input  logic              full_i,
  output logic              push_o,
  output stt_pkg::bundle_t  bundle_o
);

  logic [2:0]     mode_q, mode_d;
  stt_pkg::pos_t  pos_q, pos_d;
  stt_pkg::pos_t  tpos_q, tpos_d;

  logic [7:0]     c;
  logic           accept;
  logic           slash, cmt_open, sep, punct, blank, in_cmt;
  logic           run_n, word_n, nb_end, nb_punct, nb_flush;
  stt_pkg::pos_t  p, p_adv;
  logic [15:0]    wlen;
  stt_pkg::token_t slot [stt_pkg::ResPerByte];
  logic [stt_pkg::ResPerByte-1:0] slot_v;
  logic [1:0]     n;

  assign c      = char_i.char_in;
  assign accept = char_i.valid && char_i.ready;
  assign char_i.ready = !full_i;

  always_comb begin
    slash    = (mode_q == stt_pkg::ModeSlashEmpty) || (mode_q == stt_pkg::ModeSlashWord);
    cmt_open = (c == stt_pkg::ChSlash) || (c == stt_pkg::ChStar);
    sep      = (c == stt_pkg::ChSpace) || (c == stt_pkg::ChNl);
    blank    = sep || (c == stt_pkg::ChTab);
    punct    = stt_pkg::is_punct(c);
    in_cmt   = (mode_q == stt_pkg::ModeLine) || (mode_q == stt_pkg::ModeBlock) ||
               (mode_q == stt_pkg::ModeStar);
    // a held slash is counted before the byte that follows it
    p        = slash ? stt_pkg::advance_pos(pos_q, stt_pkg::ChSlash) : pos_q;
    p_adv    = stt_pkg::advance_pos(p, c);

    run_n    = (slash && !cmt_open) || (mode_q == stt_pkg::ModeEmpty) ||
               (mode_q == stt_pkg::ModeWord) || (mode_q == stt_pkg::ModeSkip && !blank) ||
               (in_cmt && c == stt_pkg::ChNul);
    word_n   = (mode_q == stt_pkg::ModeWord);
    nb_end   = run_n && (c == stt_pkg::ChNul);
    nb_punct = run_n && (c != stt_pkg::ChNul) && (c != stt_pkg::ChSlash) && !sep && punct;
    nb_flush = run_n && word_n && (c != stt_pkg::ChSlash) &&
               ((c == stt_pkg::ChNul) || sep || punct);

    wlen = (pos_q.off >= tpos_q.off) ? (pos_q.off - tpos_q.off) : 16'd0;

    slot[0] = '{token_kind: stt_pkg::KindWord, start_offset: tpos_q.off,
                token_length: wlen, line_number: tpos_q.line,
                column_number: tpos_q.col, punct_char: 8'h00};
    slot[1] = '{token_kind: stt_pkg::KindPunct, start_offset: pos_q.off,
                token_length: 16'd1, line_number: pos_q.line,
                column_number: pos_q.col, punct_char: stt_pkg::ChSlash};
    if (nb_end) begin
      slot[2] = '{token_kind: stt_pkg::KindEnd, start_offset: 16'd0, token_length: 16'd0,
                  line_number: 16'd0, column_number: 16'd0, punct_char: 8'h00};
    end else begin
      slot[2] = '{token_kind: stt_pkg::KindPunct, start_offset: p.off,
                  token_length: 16'd1, line_number: p.line,
                  column_number: p.col, punct_char: c};
    end

    slot_v[0] = (slash && !cmt_open && mode_q == stt_pkg::ModeSlashWord) || nb_flush;
    slot_v[1] = slash && !cmt_open;
    slot_v[2] = nb_end || nb_punct;

    // pack the valid slots to the front
    n = 2'd0;
    bundle_o.recs = '0;
    for (int i = 0; i < stt_pkg::ResPerByte; i++) begin
      if (slot_v[i]) begin
        bundle_o.recs[n] = slot[i];
        n = n + 2'd1;
      end
    end
    bundle_o.count = n;
  end

  assign push_o = accept && (n != 2'd0);

  always_comb begin
    mode_d = mode_q;
    pos_d  = pos_q;
    tpos_d = tpos_q;
    priority if (run_n) begin
      priority if (c == stt_pkg::ChNul) begin
        mode_d = stt_pkg::ModeEmpty;
        pos_d  = stt_pkg::PosReset;
        tpos_d = stt_pkg::PosReset;
      end else if (c == stt_pkg::ChSlash) begin
        mode_d = word_n ? stt_pkg::ModeSlashWord : stt_pkg::ModeSlashEmpty;
      end else if (sep) begin
        mode_d = stt_pkg::ModeSkip;
        pos_d  = p_adv;
      end else if (punct) begin
        mode_d = stt_pkg::ModeEmpty;
        pos_d  = p_adv;
      end else begin
        if (!word_n) begin
          tpos_d = p;
          mode_d = stt_pkg::ModeWord;
        end
        pos_d = p_adv;
      end
    end else if (slash) begin
      mode_d = (c == stt_pkg::ChSlash) ? stt_pkg::ModeLine : stt_pkg::ModeStar;
      pos_d  = p_adv;
    end else begin
      pos_d = p_adv;
      unique case (mode_q)
        stt_pkg::ModeLine: begin
          if (c == stt_pkg::ChNl) mode_d = stt_pkg::ModeSkip;
        end
        stt_pkg::ModeBlock, stt_pkg::ModeStar: begin
          priority if (mode_q == stt_pkg::ModeStar && c == stt_pkg::ChSlash) begin
            mode_d = stt_pkg::ModeSkip;
          end else if (c == stt_pkg::ChStar) begin
            mode_d = stt_pkg::ModeStar;
          end else begin
            mode_d = stt_pkg::ModeBlock;
          end
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= stt_pkg::ModeEmpty;
      pos_q  <= stt_pkg::PosReset;
      tpos_q <= stt_pkg::PosReset;
    end else if (accept) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      tpos_q <= tpos_d;
    end
  end

  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && c == stt_pkg::ChNul) |=>
      (mode_q == stt_pkg::ModeEmpty && pos_q == stt_pkg::PosReset))
    else $error("text end did not restart the scanner");

endmodule

// File: sv/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue
// Short queue of token bundles between the scanner and the token output.
// ----------------------------------------------------------------------------
module stt_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  stt_pkg::bundle_t  bundle_i,
  output logic              full_o,
  input  logic              pop_i,
  output stt_pkg::bundle_t  head_o,
  output logic              empty_o
);

  stt_pkg::bundle_t                 mem_q [stt_pkg::QueueDepth];
  logic [stt_pkg::QueuePtrW-1:0]    wr_q, rd_q;
  logic [stt_pkg::QueueCntW-1:0]    cnt_q;

  assign full_o  = (cnt_q == stt_pkg::QueueCntW'(stt_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= bundle_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("bundle queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("bundle queue underflow");

endmodule

// File: sv/stt_back.sv
// ----------------------------------------------------------------------------
// stt_back
// Token output: walks through the head bundle one token a cycle into the
// output register while the output is not stalled.
// ----------------------------------------------------------------------------
module stt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stt_pkg::bundle_t  head_i,
  input  logic              empty_i,
  output logic              pop_o,
  stt_token_if.source       token_o
);

  logic [1:0]       idx_q;
  logic             valid_q;
  stt_pkg::token_t  tok_q;
  logic             last_q;
  logic             load, is_last;

  assign load    = !empty_i && (!valid_q || token_o.ready);
  assign is_last = (idx_q == (head_i.count - 2'd1));
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i) begin
    if (load) begin
      tok_q  <= head_i.recs[idx_q];
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
    end else if (token_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  assign token_o.valid         = valid_q;
  assign token_o.token_kind    = tok_q.token_kind;
  assign token_o.start_offset  = tok_q.start_offset;
  assign token_o.token_length  = tok_q.token_length;
  assign token_o.line_number   = tok_q.line_number;
  assign token_o.column_number = tok_q.column_number;
  assign token_o.punct_char    = tok_q.punct_char;
  assign token_o.last_result   = last_q;

  a_idx_in_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (idx_q < head_i.count))
    else $error("token index beyond head bundle");

endmodule

// File: sv/source_text_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit
// Splits a byte stream of source text into word and punctuation tokens,
// drops comments and closes each text with an end marker.
// ----------------------------------------------------------------------------
//  channel   dir  carries                                  handshake
//  char_i    in   char_in, one text byte (0 ends text)     valid/ready
//  token_o   out  kind, offset, length, line, column,      valid/ready
//                 punct_char, last_result
//
// a byte is taken every cycle while the bundle queue (4 entries) has room
// one byte makes zero to three tokens; the scanner packs them into one queue
// entry and, while token_o is not stalled, the output stage sends one
// token per cycle from the queue head into the output register
// a stalled output fills the queue and then holds char_i.ready low
// reset puts the scanner at the start of a text with the queue empty
module source_text_tokenizer_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  stt_char_if.sink      char_i,
  stt_token_if.source   token_o
);

  logic              push, full, pop, empty;
  stt_pkg::bundle_t  bundle, head;

  stt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_i   (char_i),
    .full_i   (full),
    .push_o   (push),
    .bundle_o (bundle)
  );

  stt_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle),
    .full_o   (full),
    .pop_i    (pop),
    .head_o   (head),
    .empty_o  (empty)
  );

  stt_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .empty_i  (empty),
    .pop_o    (pop),
    .token_o  (token_o)
  );

endmodule
